>>> rtl/ccrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrr_pkg: shared definitions for the CRC checked record ring
// Sizes, response codes, controller states, the command and status bundles
// between controller and datapath, and the byte-wise CRC-32 update.
// ----------------------------------------------------------------------------
package ccrr_pkg;

  localparam int RECORD_BYTES = 32;
  localparam int SLOT_COUNT   = 4;

  localparam int MEM_DEPTH = SLOT_COUNT * RECORD_BYTES;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int SLOT_W    = $clog2(SLOT_COUNT);
  localparam int IDX_W     = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int CNT_W     = $clog2(RECORD_BYTES + 1);

  localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

  typedef enum logic [1:0] {
    RSP_OK      = 2'd0,
    RSP_TOO_OLD = 2'd1,
    RSP_BAD_CRC = 2'd2,
    RSP_PUT     = 2'd3
  } rsp_code_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_EMIT,
    S_AGE,
    S_CHK,
    S_FOLD,
    S_CMP,
    S_STR_RD,
    S_STR_LD
  } state_t;

  typedef struct packed {
    logic      clr_step;
    logic      put_byte;
    logic      fill_byte;
    logic      get_start;
    logic      retry;
    logic      chk_rd;
    logic      str_rd;
    logic      idx_clr;
    logic      out_stream;
    logic      out_code;
    rsp_code_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic put_full;
    logic idx_last;
    logic too_old;
    logic crc_ok;
    logic out_free;
  } dp_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] a;
    a = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      a = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
    end
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [IDX_W-1:0] idx);
    return ADDR_W'(slot) * ADDR_W'(RECORD_BYTES) + ADDR_W'(idx);
  endfunction

endpackage

>>> rtl/ccrr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrr_if: request and response channels of the CRC checked record ring
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ccrr_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] now_sec;
  logic [31:0] max_age_sec;

  modport source (output valid, op, data_byte, last_byte, now_sec, max_age_sec,
                  input ready);
  modport sink (input valid, op, data_byte, last_byte, now_sec, max_age_sec,
                output ready);
endinterface

interface ccrr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, out_byte, out_last, status, input ready);
  modport sink (input valid, out_byte, out_last, status, output ready);
endinterface

>>> rtl/ccrr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ccrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ccrr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrr_datapath: storage and arithmetic of the record ring
// Payload RAM, slot timestamps and CRCs, the put CRC accumulator, the check
// CRC engine, the age compare and the response register.
// ----------------------------------------------------------------------------
module ccrr_datapath
  import ccrr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ccrr_pkg::dp_cmd_t   cmd,
  output ccrr_pkg::dp_stat_t  stat,
  input  logic [7:0]          data_byte,
  input  logic [31:0]         now_sec,
  input  logic [31:0]         max_age_sec,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic [1:0]          status
);

  logic [31:0]       ts   [SLOT_COUNT];
  logic [31:0]       crcs [SLOT_COUNT];
  logic [SLOT_W-1:0] newest;
  logic [SLOT_W-1:0] target;
  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] prev;
  logic [31:0]       put_acc;
  logic [31:0]       put_acc_next;
  logic [CNT_W-1:0]  put_cnt;
  logic [31:0]       put_now;
  logic [31:0]       now_q;
  logic [31:0]       limit_q;
  logic [CNT_W-1:0]  idx;
  logic [31:0]       chk_acc;
  logic              fold;
  logic [ADDR_W-1:0] clr_addr;
  logic              put_write;
  logic              commit;
  logic [7:0]        wbyte;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  always_comb begin
    target = (newest == SLOT_W'(SLOT_COUNT - 1)) ? '0 : newest + 1'b1;
    prev   = (cur == '0) ? SLOT_W'(SLOT_COUNT - 1) : cur - 1'b1;
  end

  // A put byte or a zero fill byte goes into the slot after the newest one.
  assign put_write    = cmd.put_byte | cmd.fill_byte;
  assign wbyte        = cmd.put_byte ? data_byte : 8'd0;
  assign put_acc_next = crc_byte(put_acc, wbyte);
  assign commit       = put_write && (put_cnt == CNT_W'(RECORD_BYTES - 1));

  always_comb begin
    ram_we    = cmd.clr_step | put_write;
    ram_waddr = cmd.clr_step ? clr_addr : slot_addr(target, put_cnt[IDX_W-1:0]);
    ram_wdata = cmd.clr_step ? 8'd0 : wbyte;
    ram_re    = cmd.chk_rd | cmd.str_rd;
  end

  ccrr_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot_addr(cur, idx[IDX_W-1:0])),
    .rdata (ram_rdata)
  );

  // Put side: accumulator, fill count and commit of the slot metadata.
  always_ff @(posedge clk) begin
    if (rst) begin
      put_acc <= CRC_INIT;
      put_cnt <= '0;
      newest  <= '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        ts[s]   <= '0;
        crcs[s] <= '0;
      end
    end else if (put_write) begin
      if (commit) begin
        ts[target]   <= cmd.put_byte ? now_sec : put_now;
        crcs[target] <= ~put_acc_next;
        newest       <= target;
        put_acc      <= CRC_INIT;
        put_cnt      <= '0;
      end else begin
        put_acc <= put_acc_next;
        put_cnt <= put_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      put_now <= now_sec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Get side: slot pointer, byte index and the check CRC engine. Read data
  // comes from the registered RAM read port, so folding trails the read issue.
  always_ff @(posedge clk) begin
    if (rst) begin
      fold <= 1'b0;
    end else begin
      fold <= cmd.chk_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.get_start) begin
      now_q   <= now_sec;
      limit_q <= max_age_sec;
      cur     <= newest;
    end else if (cmd.retry) begin
      cur <= prev;
    end

    if (cmd.get_start || cmd.retry || cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.chk_rd || cmd.out_stream) begin
      idx <= idx + 1'b1;
    end

    if (cmd.get_start || cmd.retry) begin
      chk_acc <= CRC_INIT;
    end else if (fold) begin
      chk_acc <= crc_byte(chk_acc, ram_rdata);
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_stream || cmd.out_code) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_stream) begin
      out_byte <= ram_rdata;
      out_last <= stat.idx_last;
      status   <= RSP_OK;
    end else if (cmd.out_code) begin
      out_byte <= 8'd0;
      out_last <= 1'b1;
      status   <= cmd.code;
    end
  end

  always_comb begin
    stat.clr_done = (clr_addr == ADDR_W'(MEM_DEPTH - 1));
    stat.put_full = (put_cnt == CNT_W'(RECORD_BYTES - 1));
    stat.idx_last = (idx == CNT_W'(RECORD_BYTES - 1));
    stat.too_old  = (now_q - ts[cur]) > limit_q;
    stat.crc_ok   = (~chk_acc == crcs[cur]);
    stat.out_free = ~out_valid | out_ready;
  end

endmodule

>>> rtl/ccrr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrr_ctrl: sequencer of the record ring
// Runs the clearing pass, puts with zero fill, the age and CRC checks with
// one retry, and the streaming of a record or a single status response.
// ----------------------------------------------------------------------------
module ccrr_ctrl
  import ccrr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                op,
  input  logic                last_byte,
  input  ccrr_pkg::dp_stat_t  stat,
  output ccrr_pkg::dp_cmd_t   cmd
);

  state_t    state;
  state_t    state_next;
  rsp_code_t code;
  rsp_code_t code_next;
  logic      retried;
  logic      retried_next;
  logic      take;

  assign req_ready = (state == S_IDLE);
  assign take      = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      code    <= RSP_OK;
      retried <= 1'b0;
    end else begin
      state   <= state_next;
      code    <= code_next;
      retried <= retried_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          if (op) begin
            state_next = S_AGE;
          end else if (stat.put_full) begin
            state_next = S_EMIT;
          end else if (last_byte) begin
            state_next = S_FILL;
          end
        end
      end
      S_FILL: begin
        if (stat.put_full) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      S_AGE: begin
        state_next = stat.too_old ? S_EMIT : S_CHK;
      end
      S_CHK: begin
        if (stat.idx_last) state_next = S_FOLD;
      end
      S_FOLD: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.crc_ok) begin
          state_next = S_STR_RD;
        end else if (retried) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_AGE;
        end
      end
      S_STR_RD: begin
        state_next = S_STR_LD;
      end
      S_STR_LD: begin
        if (stat.out_free) state_next = stat.idx_last ? S_IDLE : S_STR_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.code     = code;
    code_next    = code;
    retried_next = retried;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        if (take) begin
          if (op) begin
            cmd.get_start = 1'b1;
            retried_next  = 1'b0;
          end else begin
            cmd.put_byte = 1'b1;
            code_next    = RSP_PUT;
          end
        end
      end
      S_FILL: cmd.fill_byte = 1'b1;
      S_EMIT: cmd.out_code = stat.out_free;
      S_AGE: begin
        if (stat.too_old) code_next = RSP_TOO_OLD;
      end
      S_CHK: cmd.chk_rd = 1'b1;
      S_CMP: begin
        if (stat.crc_ok) begin
          cmd.idx_clr = 1'b1;
        end else if (retried) begin
          code_next = RSP_BAD_CRC;
        end else begin
          cmd.retry    = 1'b1;
          retried_next = 1'b1;
        end
      end
      S_STR_RD: cmd.str_rd = 1'b1;
      S_STR_LD: cmd.out_stream = stat.out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/crc_checked_record_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_record_ring: ring of fixed-size records guarded by CRC-32
// Puts stream bytes into the slot after the newest one; gets return the newest
// record, or the prior one after a bad CRC, if young and CRC-good; else a status.
// ----------------------------------------------------------------------------
//   Channel  Dir  Moves                       Request
//   req      in   op, byte, last, time, limit  one put byte or one get
//   rsp      out  byte, last, status           one response byte or status
//
// A put byte is taken in S_IDLE; a short record is zero filled in S_FILL, and
// the committing byte gets a status response from S_EMIT. A get is taken in
// S_IDLE; each slot checked (one retry at most) passes S_AGE, S_CHK over all
// RECORD_BYTES bytes, S_FOLD and S_CMP, then each byte streams through S_STR_RD
// and S_STR_LD for the registered RAM read, or one status response leaves from
// S_EMIT. After reset a clearing pass zeroes all MEM_DEPTH (128) payload RAM
// bytes before the first request is taken. Responses leave through an output
// register, so a stalled consumer only holds the block at its next response.
// ----------------------------------------------------------------------------
module crc_checked_record_ring
  import ccrr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  ccrr_req_if.sink   req,
  ccrr_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ccrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .op        (req.op),
    .last_byte (req.last_byte),
    .stat      (stat),
    .cmd       (cmd)
  );

  ccrr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .data_byte   (req.data_byte),
    .now_sec     (req.now_sec),
    .max_age_sec (req.max_age_sec),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_byte    (rsp.out_byte),
    .out_last    (rsp.out_last),
    .status      (rsp.status)
  );

endmodule
